[hdl/fsf_pkg.sv]
// Shared types, character codes and constants of the format string integer formatter.
package fsf_pkg;

	// Widest field width a specifier may request.
	localparam int MAX_WIDTH = 60;

	// Depth of the command queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Digit storage: binary needs the most slots.
	localparam int DIG_SLOTS   = 16;
	localparam int DIG_IDX_W   = $clog2(DIG_SLOTS);
	localparam int DEC_DIGITS  = 5;
	localparam int OCT_DIGITS  = 6;
	localparam int HEX_DIGITS  = 4;

	// Divide by ten: q = (v * DEC_RECIP) >> DEC_SHIFT is exact for 16-bit v.
	localparam logic [15:0] DEC_RECIP = 16'd52429;
	localparam int          DEC_SHIFT = 19;

	// Configuration register indexes.
	localparam logic [2:0] REG_WIDTH_EN = 3'd0;
	localparam logic [2:0] REG_ALT_EN   = 3'd1;
	localparam logic [2:0] REG_BIN_EN   = 3'd2;
	localparam logic [2:0] REG_OCT_EN   = 3'd3;
	localparam logic [2:0] REG_CHAR_EN  = 3'd4;

	// Character codes.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_X  = 8'h58;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_B  = 8'h62;
	localparam logic [7:0] CH_LO_C  = 8'h63;
	localparam logic [7:0] CH_LO_D  = 8'h64;
	localparam logic [7:0] CH_LO_I  = 8'h69;
	localparam logic [7:0] CH_LO_O  = 8'h6F;
	localparam logic [7:0] CH_LO_P  = 8'h70;
	localparam logic [7:0] CH_LO_U  = 8'h75;
	localparam logic [7:0] CH_LO_X  = 8'h78;

	typedef enum logic [1:0] {
		BASE_DEC,
		BASE_BIN,
		BASE_OCT,
		BASE_HEX
	} base_t;

	typedef enum logic {
		CMD_CHAR,
		CMD_CONV
	} cmd_kind_t;

	// One unit of work for the back end. For a conversion, arg holds the magnitude.
	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  ch;
		logic [15:0] arg;
		base_t       base;
		logic        negate;
		logic        upper;
		logic [5:0]  cols;
		logic        left;
		logic        zero_pad;
		logic        prefix;
	} fsf_cmd_t;

	// Feature enables from the configuration registers.
	typedef struct packed {
		logic width_en;
		logic alt_en;
		logic bin_en;
		logic oct_en;
		logic char_en;
	} fsf_cfg_t;

endpackage

[hdl/fsf_queue.sv]
// Small command queue between the parser front end and the emitter back end.
module fsf_queue
	import fsf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  fsf_cmd_t push_data,
	output logic     full,
	input  logic     pop,
	output fsf_cmd_t pop_data,
	output logic     empty
);

	fsf_cmd_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]    wr_ptr_q;
	logic [QPTR_W-1:0]    rd_ptr_q;
	logic [QPTR_W:0]      count_q;

	assign full     = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// Storage is written only on push.
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + (QPTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hdl/fsf_front.sv]
// Front end: accepts format bytes, tracks the specifier state and issues commands.
module fsf_front
	import fsf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  fsf_cfg_t    cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  format_char,
	input  logic [15:0] argument,
	input  logic        q_full,
	output logic        cmd_push,
	output fsf_cmd_t    cmd
);

	logic       in_spec_q, zpad_q, left_q, alt_q;
	logic [5:0] fw_q;
	logic       in_spec_d, zpad_d, left_d, alt_d;
	logic [5:0] fw_d;
	logic       emit;
	logic       accept;
	logic       is_digit;
	logic       is_conv;
	logic       is_signed;
	logic [9:0] wsum;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign cmd_push = accept && emit;

	assign is_digit  = (format_char >= CH_ZERO) && (format_char <= CH_NINE);
	assign is_signed = (format_char == CH_LO_D) || (format_char == CH_LO_I);
	assign is_conv   = is_signed || (format_char == CH_LO_U) || (format_char == CH_LO_X)
		|| (format_char == CH_UP_X) || (format_char == CH_LO_P)
		|| ((format_char == CH_LO_B) && cfg.bin_en)
		|| ((format_char == CH_LO_O) && cfg.oct_en);

	// Next field width when a width digit arrives.
	assign wsum = 10'(fw_q) * 10'd10 + 10'(format_char[3:0]);

	// Classify the byte against the specifier state.
	always_comb begin
		in_spec_d = in_spec_q;
		zpad_d    = zpad_q;
		left_d    = left_q;
		alt_d     = alt_q;
		fw_d      = fw_q;
		emit      = 1'b0;
		cmd       = '0;
		cmd.kind  = CMD_CHAR;
		cmd.ch    = format_char;

		if (format_char == CH_NUL) begin
			emit      = 1'b1;
			in_spec_d = 1'b0;
			zpad_d    = 1'b0;
			left_d    = 1'b0;
			alt_d     = 1'b0;
			fw_d      = '0;
		end else if (!in_spec_q) begin
			if (format_char == CH_PCT) begin
				in_spec_d = 1'b1;
			end else begin
				emit = 1'b1;
			end
		end else if (is_digit && cfg.width_en) begin
			fw_d = (wsum > 10'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : wsum[5:0];
			if (wsum == '0) begin
				zpad_d = 1'b1;
			end
		end else if ((format_char == CH_HASH) && cfg.alt_en) begin
			alt_d = 1'b1;
		end else if ((format_char == CH_DASH) && cfg.width_en) begin
			left_d = 1'b1;
		end else begin
			// Any other byte ends the specifier.
			in_spec_d = 1'b0;
			zpad_d    = 1'b0;
			left_d    = 1'b0;
			alt_d     = 1'b0;
			fw_d      = '0;
			if ((format_char == CH_LO_C) && cfg.char_en) begin
				emit   = 1'b1;
				cmd.ch = argument[7:0];
			end else if (format_char == CH_PCT) begin
				emit = 1'b1;
			end else if (is_conv) begin
				emit         = 1'b1;
				cmd.kind     = CMD_CONV;
				cmd.negate   = is_signed && argument[15];
				cmd.arg      = cmd.negate ? (~argument + 16'd1) : argument;
				cmd.upper    = (format_char != CH_LO_X);
				cmd.cols     = cfg.width_en ? fw_q : '0;
				cmd.left     = cfg.width_en && left_q;
				cmd.zero_pad = zpad_q;
				cmd.prefix   = cfg.alt_en && (alt_q || (format_char == CH_LO_P));
				if (format_char == CH_LO_B) begin
					cmd.base = BASE_BIN;
				end else if (format_char == CH_LO_O) begin
					cmd.base = BASE_OCT;
				end else if (is_signed || (format_char == CH_LO_U)) begin
					cmd.base = BASE_DEC;
				end else begin
					cmd.base = BASE_HEX;
				end
			end
		end
	end

	// Specifier state advances only on an accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_spec_q <= 1'b0;
			zpad_q    <= 1'b0;
			left_q    <= 1'b0;
			alt_q     <= 1'b0;
			fw_q      <= '0;
		end else if (accept) begin
			in_spec_q <= in_spec_d;
			zpad_q    <= zpad_d;
			left_q    <= left_d;
			alt_q     <= alt_d;
			fw_q      <= fw_d;
		end
	end

endmodule

[hdl/fsf_back.sv]
// Back end: extracts digits and emits the justified characters of each command.
module fsf_back
	import fsf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  fsf_cmd_t   cmd,
	output logic       cmd_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       last_of_run
);

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_EXTRACT = 8'b0000_0010,
		S_MEASURE = 8'b0000_0100,
		S_PADL    = 8'b0000_1000,
		S_SIGN    = 8'b0001_0000,
		S_PFX0    = 8'b0010_0000,
		S_PFXX    = 8'b0100_0000,
		S_DIGIT   = 8'b1000_0000
	} state_t;

	// Right padding reuses the digit count register; see the PADR flag below.
	state_t       state_q, state_d;
	logic         padr_q, padr_d;
	logic [5:0]   cnt_q, cnt_d;
	logic         out_v_q;
	logic [7:0]   out_char_q;
	logic         out_last_q;

	logic [15:0]  val_q;
	base_t        base_q;
	logic         neg_q, upper_q, left_q, zpad_q, prefix_q;
	logic [5:0]   cols_q;
	logic [3:0]   dig_q [DIG_SLOTS];
	logic [2:0]   idx_q;
	logic [4:0]   len_q;
	logic [5:0]   pad_q;

	logic         fire;
	logic         emit;
	logic [7:0]   emit_char;
	logic         emit_last;
	logic         load_conv;
	logic [31:0]  dec_prod;
	logic [15:0]  dec_quo;
	logic [15:0]  dec_rem;
	logic [3:0]   p2_dig [DIG_SLOTS];
	logic [4:0]   len_c;
	logic [5:0]   pad_c;
	logic [5:0]   cnt_m1;
	logic [3:0]   cur_dig;
	state_t       after_pad;

	assign fire        = !out_v_q || out_ready;
	assign out_valid   = out_v_q;
	assign out_char    = out_char_q;
	assign last_of_run = out_last_q;
	assign load_conv   = (state_q == S_IDLE) && cmd_valid && (cmd.kind == CMD_CONV);

	// One decimal digit per cycle by reciprocal multiplication.
	assign dec_prod = val_q * DEC_RECIP;
	assign dec_quo  = 16'(dec_prod[31:DEC_SHIFT]);
	assign dec_rem  = val_q - ((dec_quo << 3) + (dec_quo << 1));

	// Power-of-two bases split into digits directly.
	always_comb begin
		logic [31:0] sh;
		sh = '0;
		for (int i = 0; i < DIG_SLOTS; i++) begin
			p2_dig[i] = '0;
			case (base_q)
				BASE_BIN: p2_dig[i] = {3'b000, val_q[i]};
				BASE_OCT: begin
					sh = {16'h0000, val_q} >> (3 * i);
					if (i < OCT_DIGITS) begin
						p2_dig[i] = {1'b0, sh[2:0]};
					end
				end
				BASE_HEX: begin
					sh = {16'h0000, val_q} >> (4 * i);
					if (i < HEX_DIGITS) begin
						p2_dig[i] = sh[3:0];
					end
				end
				default: p2_dig[i] = '0;
			endcase
		end
	end

	// Significant digit count, at least one, and the padding it leaves.
	always_comb begin
		len_c = 5'd1;
		for (int i = 0; i < DIG_SLOTS; i++) begin
			if (dig_q[i] != '0) begin
				len_c = 5'(i + 1);
			end
		end
		pad_c = (cols_q > 6'(len_c)) ? (cols_q - 6'(len_c)) : '0;
	end

	assign cnt_m1  = cnt_q - 6'd1;
	assign cur_dig = dig_q[cnt_m1[DIG_IDX_W-1:0]];
	assign after_pad = neg_q ? S_SIGN : (prefix_q ? S_PFX0 : S_DIGIT);

	// Sequencer: one output character per free output slot.
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		padr_d    = padr_q;
		emit      = 1'b0;
		emit_char = CH_SPACE;
		emit_last = 1'b0;
		cmd_pop   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					if (cmd.kind == CMD_CHAR) begin
						if (fire) begin
							cmd_pop   = 1'b1;
							emit      = 1'b1;
							emit_char = cmd.ch;
							emit_last = 1'b1;
						end
					end else begin
						cmd_pop = 1'b1;
						padr_d  = 1'b0;
						state_d = S_EXTRACT;
					end
				end
			end
			S_EXTRACT: begin
				if ((base_q != BASE_DEC) || (idx_q == 3'(DEC_DIGITS - 1))) begin
					state_d = S_MEASURE;
				end
			end
			S_MEASURE: begin
				if (!left_q && (pad_c != '0)) begin
					state_d = S_PADL;
					cnt_d   = pad_c;
				end else begin
					state_d = after_pad;
					cnt_d   = 6'(len_c);
				end
			end
			S_PADL: begin
				if (fire) begin
					emit      = 1'b1;
					emit_char = zpad_q ? CH_ZERO : CH_SPACE;
					if (cnt_q == 6'd1) begin
						state_d = after_pad;
						cnt_d   = 6'(len_q);
					end else begin
						cnt_d = cnt_m1;
					end
				end
			end
			S_SIGN: begin
				if (fire) begin
					emit      = 1'b1;
					emit_char = CH_DASH;
					state_d   = prefix_q ? S_PFX0 : S_DIGIT;
				end
			end
			S_PFX0: begin
				if (fire) begin
					emit      = 1'b1;
					emit_char = CH_ZERO;
					state_d   = S_PFXX;
				end
			end
			S_PFXX: begin
				if (fire) begin
					emit      = 1'b1;
					emit_char = CH_LO_X;
					state_d   = S_DIGIT;
				end
			end
			S_DIGIT: begin
				if (fire) begin
					emit = 1'b1;
					if (padr_q) begin
						emit_char = CH_SPACE;
					end else if (cur_dig < 4'd10) begin
						emit_char = CH_ZERO + 8'(cur_dig);
					end else begin
						emit_char = (upper_q ? CH_UP_A : CH_LO_A) + 8'(cur_dig) - 8'd10;
					end
					if (cnt_q == 6'd1) begin
						if (!padr_q && left_q && (pad_q != '0)) begin
							padr_d = 1'b1;
							cnt_d  = pad_q;
						end else begin
							emit_last = 1'b1;
							padr_d    = 1'b0;
							state_d   = S_IDLE;
						end
					end else begin
						cnt_d = cnt_m1;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			padr_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			padr_q  <= padr_d;
			if (fire) begin
				out_v_q <= emit;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (fire && emit) begin
			out_char_q <= emit_char;
			out_last_q <= emit_last;
		end
		if (load_conv) begin
			val_q    <= cmd.arg;
			base_q   <= cmd.base;
			neg_q    <= cmd.negate;
			upper_q  <= cmd.upper;
			cols_q   <= cmd.cols;
			left_q   <= cmd.left;
			zpad_q   <= cmd.zero_pad;
			prefix_q <= cmd.prefix;
			idx_q    <= '0;
			for (int i = 0; i < DIG_SLOTS; i++) begin
				dig_q[i] <= '0;
			end
		end else if (state_q == S_EXTRACT) begin
			if (base_q == BASE_DEC) begin
				dig_q[{1'b0, idx_q}] <= dec_rem[3:0];
				val_q                <= dec_quo;
				idx_q                <= idx_q + 3'd1;
			end else begin
				for (int i = 0; i < DIG_SLOTS; i++) begin
					dig_q[i] <= p2_dig[i];
				end
			end
		end
		if (state_q == S_MEASURE) begin
			len_q <= len_c;
			pad_q <= pad_c;
		end
	end

	// The digit count never runs past the measured length.
	a_digit_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIGIT) && !padr_q |-> (cnt_q != '0) && (cnt_q <= 6'(len_q)))
		else $error("digit index out of range");

	// Trailing padding only for left-justified conversions.
	a_padr_left: assert property (@(posedge clk) disable iff (!arst_n)
		padr_q && (state_q == S_DIGIT) |-> left_q)
		else $error("trailing padding without left justification");

	// The prefix is always the pair "0x".
	a_prefix_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PFX0) && fire |=> (state_q == S_PFXX))
		else $error("prefix split");

	// Commands are taken only between conversions.
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> (state_q == S_IDLE) && cmd_valid)
		else $error("command taken while busy");

endmodule

[hdl/format_string_integer_formatter_top.sv]
// Integer formatter for printf-style format strings: APB registers, front end, queue, back end.
//
// Usage: format bytes arrive on in_valid/in_ready with format_char and a 16-bit argument,
// one beat per byte. Characters leave on out_valid/out_ready as out_char, and
// last_of_run marks the final character caused by one input beat. Bytes that only
// update specifier state (%, flags, width digits) or form an invalid specifier produce
// no output beat. A zero byte produces a single zero character and clears the specifier.
// A literal byte passes through the command queue and the output register before it is
// offered on the output. A conversion is loaded, has its digits extracted (binary, octal
// and hex at once, decimal one digit per cycle through the divide-by-ten multiplier) and
// measured, then emits one character per cycle while the output is not stalled, up to
// 63 characters.
// Throughput: literal bytes pass at one per cycle while the output is not stalled; the
// emitter takes no new command until a conversion is done. A four-entry command queue
// lets the parser keep accepting bytes while the emitter works.
// Reset clears the specifier state, the queue and the output register and sets all
// feature enables to one. When the receiver stalls, the current character is held and
// the queue fills, after which in_ready drops. Configuration is written over APB with
// register i at byte address 4*i.
module format_string_integer_formatter_top
	import fsf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  format_char,
	input  logic [15:0] argument,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_char,
	output logic        last_of_run
);

	fsf_cfg_t   cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;
	logic       q_full, q_empty, q_push, q_pop;
	fsf_cmd_t   push_cmd, pop_cmd;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '1;
		end else if (wr_en) begin
			case (reg_idx)
				REG_WIDTH_EN: cfg_q.width_en <= pwdata[0];
				REG_ALT_EN:   cfg_q.alt_en   <= pwdata[0];
				REG_BIN_EN:   cfg_q.bin_en   <= pwdata[0];
				REG_OCT_EN:   cfg_q.oct_en   <= pwdata[0];
				REG_CHAR_EN:  cfg_q.char_en  <= pwdata[0];
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	// Register reads.
	always_comb begin
		case (reg_idx)
			REG_WIDTH_EN: prdata = {31'b0, cfg_q.width_en};
			REG_ALT_EN:   prdata = {31'b0, cfg_q.alt_en};
			REG_BIN_EN:   prdata = {31'b0, cfg_q.bin_en};
			REG_OCT_EN:   prdata = {31'b0, cfg_q.oct_en};
			REG_CHAR_EN:  prdata = {31'b0, cfg_q.char_en};
			default:      prdata = '0;
		endcase
	end

	fsf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.format_char (format_char),
		.argument    (argument),
		.q_full      (q_full),
		.cmd_push    (q_push),
		.cmd         (push_cmd)
	);

	fsf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_cmd),
		.empty     (q_empty)
	);

	fsf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (!q_empty),
		.cmd         (pop_cmd),
		.cmd_pop     (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_char    (out_char),
		.last_of_run (last_of_run)
	);

endmodule
